// ===== rtl/sbp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types, codes and widths for the signal border padding block.
// ----------------------------------------------------------------------------
package sbp_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int CNT_W     = 11;
  localparam int POS_W     = 12;
  localparam int MODE_W    = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int MAX_PAD_DEF     = 1024;

  localparam logic [MODE_W-1:0] MODE_CONST   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REFLECT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRAP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SYM     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EDGE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_FILL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_FILL  = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EMIT    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_LEFT_IDLE = 2'd0,
    PH_LEFT      = 2'd1,
    PH_RIGHT     = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SIDE = 2'd1,
    ST_READ = 2'd2
  } state_t;

endpackage

// ===== rtl/signal_border_padding.sv =====
// ----------------------------------------------------------------------------
// signal_border_padding
// Sample store with a border walk that emits at most one pad sample per emit command.
// ----------------------------------------------------------------------------
// Load and restart commands complete in the cycle they are taken and leave
// busy low, as does an emit refused for too few loaded samples. Any other
// emit raises busy while it resolves the pad side (start left, start right,
// finish), and an emit that yields a sample then waits on the synchronous
// store read; its result strobe out_valid rises in the cycle after that,
// while the next command may already transfer. An emit that yields no
// sample returns to idle without a result.
// The store is the two-port sample memory; it needs no clearing pass, as
// only loaded entries are read. The receiver cannot stall: each result is on
// the out_ ports for exactly one cycle. Configuration writes are always ready
// and must be issued only while no emit is in flight.
module signal_border_padding
  import sbp_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_PAD     = MAX_PAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [SAMPLE_W-1:0]  in_sample,
  output logic                 out_valid,
  output logic [POS_W-1:0]     out_position,
  output logic [SAMPLE_W-1:0]  out_value,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_wdata
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int PW   = $clog2(MAX_PAD + 1);
  localparam int CMPW = (PW > CNT_W) ? PW : CNT_W;

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_W-1:0] mem_rd_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;

  logic [MODE_W-1:0]   mode_r;
  logic [CNT_W-1:0]    lcount_r;
  logic [CNT_W-1:0]    rcount_r;
  logic [SAMPLE_W-1:0] lfill_r;
  logic [SAMPLE_W-1:0] rfill_r;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [PW-1:0]       rem_r, rem_nxt;
  logic [AW-1:0]       fold_r, fold_nxt;
  logic                desc_r, desc_nxt;
  logic [POS_W-1:0]    pos_base_r, pos_base_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  logic                walking;
  logic                edge_mode;
  logic                emit_ok;
  logic                right_side;
  logic [AW-1:0]       top;
  logic [AW-1:0]       fold_clamp;
  logic [PW-1:0]       sat_l;
  logic [PW-1:0]       sat_r;
  logic [CMPW-1:0]     lcount_ext;
  logic [CMPW-1:0]     rcount_ext;
  logic [AW-1:0]       walk_idx;
  logic                walk_desc;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state_r == ST_IDLE);

  assign walking    = (mode_r == MODE_REFLECT) || (mode_r == MODE_WRAP) ||
                      (mode_r == MODE_SYM);
  assign edge_mode  = (mode_r == MODE_EDGE);
  assign emit_ok    = !((walking && (cnt_r < CW'(2))) || (edge_mode && (cnt_r == '0)));
  assign right_side = (phase_r == PH_RIGHT);
  assign top        = (cnt_r != '0) ? AW'(cnt_r - CW'(1)) : '0;
  assign fold_clamp = (walking && (fold_r > top)) ? top : fold_r;
  assign rd_addr    = walking ? fold_clamp : (right_side ? top : '0);

  assign lcount_ext = CMPW'(lcount_r);
  assign rcount_ext = CMPW'(rcount_r);
  assign sat_l = (lcount_ext > CMPW'(MAX_PAD)) ? PW'(MAX_PAD) : PW'(lcount_ext);
  assign sat_r = (rcount_ext > CMPW'(MAX_PAD)) ? PW'(MAX_PAD) : PW'(rcount_ext);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_EMIT) && emit_ok) begin
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        priority if (phase_r == PH_LEFT_IDLE) begin
          state_nxt = ST_SIDE;
        end else if (phase_r == PH_LEFT && rem_r == '0) begin
          state_nxt = ST_SIDE;
        end else if (phase_r == PH_RIGHT && rem_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (phase_r == PH_DONE) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Walk step
  always_comb begin
    walk_idx  = fold_r;
    walk_desc = desc_r;
    if (mode_r == MODE_WRAP) begin
      if (!right_side) begin
        walk_idx = (fold_r == '0) ? top : fold_r - AW'(1);
      end else begin
        walk_idx = (fold_r >= top) ? '0 : fold_r + AW'(1);
      end
    end else if (mode_r == MODE_SYM) begin
      if (!desc_r) begin
        if (fold_r >= top) walk_desc = 1'b1;
        else walk_idx = fold_r + AW'(1);
      end else begin
        if (fold_r == '0) walk_desc = 1'b0;
        else walk_idx = fold_r - AW'(1);
      end
    end else begin
      if (!desc_r) begin
        if (fold_r >= top) begin
          walk_desc = 1'b1;
          walk_idx  = fold_r - AW'(1);
        end else begin
          walk_idx = fold_r + AW'(1);
          if (walk_idx == '0 || walk_idx == top) walk_desc = ~desc_r;
        end
      end else begin
        if (fold_r == '0) begin
          walk_desc = 1'b0;
          walk_idx  = fold_r + AW'(1);
        end else begin
          walk_idx = fold_r - AW'(1);
          if (walk_idx == '0 || walk_idx == top) walk_desc = ~desc_r;
        end
      end
    end
  end

  // Datapath and outputs
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    fold_nxt      = fold_r;
    desc_nxt      = desc_r;
    pos_base_nxt  = pos_base_r;
    mem_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = out_pos_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_LOAD: begin
              if (cnt_r < CW'(STORE_DEPTH)) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            CMD_RESTART: begin
              cnt_nxt   = '0;
              phase_nxt = PH_LEFT_IDLE;
              rem_nxt   = '0;
              fold_nxt  = '0;
              desc_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SIDE: begin
        priority if (phase_r == PH_LEFT_IDLE) begin
          phase_nxt = PH_LEFT;
          rem_nxt   = sat_l;
          desc_nxt  = 1'b0;
          if (mode_r == MODE_REFLECT) fold_nxt = AW'(1);
          else if (mode_r == MODE_WRAP) fold_nxt = top;
          else fold_nxt = '0;
        end else if (phase_r == PH_LEFT && rem_r == '0) begin
          phase_nxt = PH_RIGHT;
          rem_nxt   = sat_r;
          desc_nxt  = 1'b1;
          if (mode_r == MODE_REFLECT) begin
            fold_nxt = (cnt_r >= CW'(2)) ? AW'(cnt_r - CW'(2)) : '0;
          end else if (mode_r == MODE_WRAP) begin
            fold_nxt = '0;
            desc_nxt = 1'b0;
          end else begin
            fold_nxt = top;
          end
        end else if (phase_r == PH_RIGHT && rem_r == '0) begin
          phase_nxt = PH_DONE;
        end else if (phase_r == PH_DONE) begin
          phase_nxt = PH_DONE;
        end else begin
          fold_nxt     = fold_clamp;
          pos_base_nxt = right_side ? POS_W'(sat_l) + POS_W'(cnt_r)
                                    : POS_W'(rem_r - PW'(1));
        end
      end
      ST_READ: begin
        if (walking) begin
          fold_nxt = walk_idx;
          desc_nxt = walk_desc;
        end
        rem_nxt       = rem_r - PW'(1);
        out_valid_nxt = 1'b1;
        out_pos_nxt   = right_side ? pos_base_r + POS_W'(sat_r) - POS_W'(rem_r)
                                   : pos_base_r;
        out_value_nxt = (walking || edge_mode) ? mem_rd_r
                                               : (right_side ? rfill_r : lfill_r);
        out_last_nxt  = (rem_r == PW'(1)) && (right_side || (sat_r == '0));
      end
      default: ;
    endcase
  end

  // Sample store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= in_sample;
    end
    mem_rd_r <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CONST;
      lcount_r <= '0;
      rcount_r <= '0;
      lfill_r  <= '0;
      rfill_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAD_MODE:    mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_LEFT_COUNT:  lcount_r <= cfg_wdata[CNT_W-1:0];
        REG_RIGHT_COUNT: rcount_r <= cfg_wdata[CNT_W-1:0];
        REG_LEFT_FILL:   lfill_r  <= cfg_wdata;
        REG_RIGHT_FILL:  rfill_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_LEFT_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      fold_r      <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      fold_r      <= fold_nxt;
      desc_r      <= desc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pos_base_r  <= pos_base_nxt;
    out_pos_r   <= out_pos_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;

  a_strobe_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_READ))
    else $error("result strobe without a store read");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STORE_DEPTH))
    else $error("loaded count beyond store depth");

  a_read_side: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ((phase_r == PH_LEFT || phase_r == PH_RIGHT) && rem_r != '0))
    else $error("read without an active side");

  a_fold_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && walking) |-> (CW'(fold_r) < cnt_r))
    else $error("walk index beyond loaded samples");

  a_busy_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_EMIT && emit_ok) |=> busy)
    else $error("emit transfer did not raise busy");

endmodule
